@@ sv/fcba_pkg.sv @@
// ----------------------------------------------------------------------------
// fcba_pkg: shared types and constants of the frame counter block allocator
// Holds operation codes, counter limits and the per-domain state record.
// ----------------------------------------------------------------------------
package fcba_pkg;

    localparam int unsigned CNT_W     = 32;
    localparam int unsigned OP_W      = 3;
    localparam int unsigned NUM_DOM   = 2;

    localparam logic [CNT_W-1:0] BLOCK_SIZE  = 32'd1024;
    localparam logic [CNT_W-1:0] COUNTER_MAX = 32'hFFFF_FFFF;
    // Largest next counter from which one more block still fits
    localparam logic [CNT_W-1:0] BLOCK_LAST  = COUNTER_MAX - BLOCK_SIZE;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOCATE = 3'd0,
        OP_NEW_KEY  = 3'd1,
        OP_RESTORE  = 3'd2,
        OP_DISABLE  = 3'd3,
        OP_QUERY    = 3'd4
    } op_t;

    typedef struct packed {
        logic             on;
        logic [CNT_W-1:0] next;
        logic [CNT_W-1:0] limit;
    } dom_state_t;

    typedef struct packed {
        logic       en;
        logic       dom;
        dom_state_t st;
    } state_wr_t;

    typedef struct packed {
        logic             ok;
        logic [CNT_W-1:0] counter;
        logic             req;
        logic [CNT_W-1:0] old_end;
        logic [CNT_W-1:0] new_end;
        dom_state_t       st;
    } result_t;

endpackage

@@ sv/fcba_state.sv @@
// ----------------------------------------------------------------------------
// fcba_state: per-domain counter state
// Two entries of next counter, reserved end and enabled bit; one write port.
// ----------------------------------------------------------------------------
module fcba_state
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   rd_dom,
    output fcba_pkg::dom_state_t   rd_st,
    input  fcba_pkg::state_wr_t    wr
);
    import fcba_pkg::*;

    dom_state_t st_reg [NUM_DOM];

    // Read the selected domain
    assign rd_st = st_reg[rd_dom];

    // Hold state, update one domain per write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_DOM; i++)
            begin
                st_reg[i] <= '0;
            end
        end
        else if (wr.en)
        begin
            st_reg[wr.dom] <= wr.st;
        end
    end

endmodule

@@ sv/fcba_logic.sv @@
// ----------------------------------------------------------------------------
// fcba_logic: single-pass operation datapath
// Computes the result of one item and the new state of its domain.
// ----------------------------------------------------------------------------
module fcba_logic
(
    input  logic [fcba_pkg::OP_W-1:0]  operation,
    input  logic [fcba_pkg::CNT_W-1:0] value,
    input  logic                       persist_flag_set,
    input  logic                       store_commits,
    input  fcba_pkg::dom_state_t       cur,
    output fcba_pkg::result_t          res
);
    import fcba_pkg::*;

    logic             need_block;
    logic             past_max;
    logic [CNT_W-1:0] block_end;
    logic [CNT_W-1:0] limit_upd;
    logic             grant;
    dom_state_t       loaded;
    dom_state_t       st_next;

    // Block reservation checks for allocate
    assign need_block = cur.next >= cur.limit;
    assign past_max   = cur.next > BLOCK_LAST;
    assign block_end  = cur.next + BLOCK_SIZE;
    assign limit_upd  = (need_block && store_commits) ? block_end : cur.limit;
    assign grant      = cur.on && !(need_block && (past_max || !store_commits))
                        && !(cur.next >= limit_upd) && (cur.next != COUNTER_MAX);

    assign loaded = '{on: 1'b1, next: value, limit: value};

    // Select the operation
    always_comb
    begin
        res     = '0;
        res.ok  = 1'b1;
        st_next = cur;
        unique case (op_t'(operation))
            OP_ALLOCATE:
            begin
                res.ok = grant;
                if (cur.on && need_block && !past_max)
                begin
                    res.req     = 1'b1;
                    res.old_end = cur.limit;
                    res.new_end = block_end;
                    st_next.limit = limit_upd;
                end
                if (grant)
                begin
                    res.counter  = cur.next;
                    st_next.next = cur.next + 32'd1;
                end
            end
            OP_NEW_KEY:
            begin
                st_next = (value == '0 || value == COUNTER_MAX) ? '0 : loaded;
            end
            OP_RESTORE:
            begin
                st_next = (!persist_flag_set || value == '0) ? '0 : loaded;
            end
            OP_DISABLE:
            begin
                st_next = '0;
            end
            default:
            begin
                st_next = cur;
            end
        endcase
        res.st = st_next;
    end

endmodule

@@ sv/frame_counter_block_allocator.sv @@
// Items are held in the input register and results in the result register.
// One item per cycle while out_stall is low; state is read and written in
// the same cycle, so each item sees the state left by the one before it.
// Reset (rst_n low, asynchronous) disables and clears both domains and
// empties the input and result registers.
// ----------------------------------------------------------------------------
// frame_counter_block_allocator: top level
// Input register, single-pass datapath with domain state, result register.
// ----------------------------------------------------------------------------
module frame_counter_block_allocator
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [fcba_pkg::OP_W-1:0]  operation,
    input  logic                       domain,
    input  logic [fcba_pkg::CNT_W-1:0] value,
    input  logic                       persist_flag_set,
    input  logic                       store_commits,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic                       ok,
    output logic [fcba_pkg::CNT_W-1:0] counter,
    output logic                       reserve_request,
    output logic [fcba_pkg::CNT_W-1:0] reserve_old_end,
    output logic [fcba_pkg::CNT_W-1:0] reserve_new_end,
    output logic                       domain_enabled,
    output logic [fcba_pkg::CNT_W-1:0] next_value,
    output logic [fcba_pkg::CNT_W-1:0] reserved_end
);
    import fcba_pkg::*;

    logic             s1_valid_reg, s1_valid_next;
    logic [OP_W-1:0]  s1_op_reg;
    logic             s1_dom_reg;
    logic [CNT_W-1:0] s1_value_reg;
    logic             s1_flag_reg;
    logic             s1_commit_reg;
    logic             out_valid_reg, out_valid_next;
    result_t          res_reg;
    result_t          res_comb;
    dom_state_t       cur_st;
    state_wr_t        wr;
    logic             in_take;
    logic             advance;

    // Move the staged item on when the result register is free or drains
    assign advance  = s1_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = s1_valid_reg && out_valid_reg && out_stall;
    assign in_take  = in_valid && !in_stall;

    assign s1_valid_next  = in_take ? 1'b1 : (advance ? 1'b0 : s1_valid_reg);
    assign out_valid_next = advance ? 1'b1 :
                            ((out_valid_reg && !out_stall) ? 1'b0 : out_valid_reg);

    fcba_state u_state
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_dom (s1_dom_reg),
        .rd_st  (cur_st),
        .wr     (wr)
    );

    fcba_logic u_logic
    (
        .operation        (s1_op_reg),
        .value            (s1_value_reg),
        .persist_flag_set (s1_flag_reg),
        .store_commits    (s1_commit_reg),
        .cur              (cur_st),
        .res              (res_comb)
    );

    assign wr = '{en: advance, dom: s1_dom_reg, st: res_comb.st};

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Capture the incoming item
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            s1_op_reg     <= operation;
            s1_dom_reg    <= domain;
            s1_value_reg  <= value;
            s1_flag_reg   <= persist_flag_set;
            s1_commit_reg <= store_commits;
        end
    end

    // Capture the result
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            res_reg <= res_comb;
        end
    end

    assign out_valid       = out_valid_reg;
    assign ok              = res_reg.ok;
    assign counter         = res_reg.counter;
    assign reserve_request = res_reg.req;
    assign reserve_old_end = res_reg.old_end;
    assign reserve_new_end = res_reg.new_end;
    assign domain_enabled  = res_reg.st.on;
    assign next_value      = res_reg.st.next;
    assign reserved_end    = res_reg.st.limit;

`ifndef SYNTHESIS
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (s1_valid_reg && out_valid_reg))
        else $error("input stalled without a staged item and a held result");

    a_disabled_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !domain_enabled) |-> (next_value == '0 && reserved_end == '0))
        else $error("disabled domain reports nonzero counters");

    a_next_within_end: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && domain_enabled) |-> (next_value <= reserved_end))
        else $error("next counter beyond reserved end");

    a_fail_no_counter: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !ok) |-> (counter == '0))
        else $error("failed allocate returned a counter");

    a_grant_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (advance && s1_op_reg == OP_ALLOCATE && res_comb.ok)
        |-> (res_comb.st.next == cur_st.next + 32'd1))
        else $error("granted allocate did not advance the counter");
`endif

endmodule
